>>> hw/rtl/tvsf_pkg.sv
// Shared types and constants for the TLB victim select and fill block.
// No dependencies; imported by every module of the block.
package tvsf_pkg;

    localparam int ENTRIES_DEF = 64;
    localparam int LOCK_IDX_W  = 6;
    localparam int ENTRY_IDX_W = 6;
    localparam int ADDR_W      = 32;
    localparam int PAGE_OFS_W  = 12;
    localparam int REQ_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int IN_DATA_W   = 80;
    localparam int OUT_DATA_W  = 80;

    localparam logic [REQ_W-1:0] REQ_TICK    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOCK    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_REPLACE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ALL_LOCKED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_KIND   = 2'd2;

    typedef struct packed {
        logic idle;
        logic done;
        logic found;
    } t_scan_stat;

endpackage

>>> hw/rtl/tvsf_lock_file.sv
// Per-entry lock bits in flip-flops, cleared by reset, with one read port.
// Depends on tvsf_pkg.
module tvsf_lock_file #(
    parameter int ENTRIES = tvsf_pkg::ENTRIES_DEF,
    parameter int PW      = $clog2(ENTRIES)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_set,
    input  logic [tvsf_pkg::LOCK_IDX_W-1:0] i_set_idx,
    input  logic [PW-1:0]                   i_rd_idx,
    output logic                            o_locked
);
    import tvsf_pkg::*;

    localparam int IW = (PW > LOCK_IDX_W) ? PW : LOCK_IDX_W;

    logic [ENTRIES-1:0] r_lock;
    logic [IW-1:0]      w_set_ext;
    logic               w_set_ok;

    assign w_set_ext = IW'(i_set_idx);
    assign w_set_ok  = (32'(i_set_idx) < 32'(ENTRIES));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lock <= '0;
        end else if (i_set && w_set_ok) begin
            r_lock[w_set_ext[PW-1:0]] <= 1'b1;
        end
    end

    assign o_locked = r_lock[i_rd_idx];

endmodule

>>> hw/rtl/tvsf_scan_ctrl.sv
// Victim pointer and scan sequencer: steps one entry per cycle through the lock bits.
// Depends on tvsf_pkg.
module tvsf_scan_ctrl #(
    parameter int ENTRIES = tvsf_pkg::ENTRIES_DEF,
    parameter int PW      = $clog2(ENTRIES)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_tick,
    input  logic                 i_replace,
    input  logic                 i_ack,
    input  logic                 i_locked,
    output logic [PW-1:0]        o_scan_idx,
    output tvsf_pkg::t_scan_stat o_stat
);
    import tvsf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    localparam logic [PW-1:0] LAST = PW'(ENTRIES - 1);

    t_state        r_state, n_state;
    logic [PW-1:0] r_ptr, n_ptr;
    logic [PW-1:0] r_scan, n_scan;
    logic [PW-1:0] r_cnt, n_cnt;
    logic          r_found, n_found;

    function automatic logic [PW-1:0] f_next(input logic [PW-1:0] p);
        return (p == LAST) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        n_state = r_state;
        n_ptr   = r_ptr;
        n_scan  = r_scan;
        n_cnt   = r_cnt;
        n_found = r_found;
        unique case (r_state)
            S_IDLE: begin
                if (i_tick) begin
                    n_ptr = f_next(r_ptr);
                end
                if (i_replace) begin
                    n_scan  = r_ptr;
                    n_cnt   = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!i_locked) begin
                    n_found = 1'b1;
                    n_ptr   = r_scan;
                    n_state = S_DONE;
                end else if (r_cnt == LAST) begin
                    n_found = 1'b0;
                    n_state = S_DONE;
                end else begin
                    n_scan = f_next(r_scan);
                    n_cnt  = r_cnt + 1'b1;
                end
            end
            S_DONE: begin
                if (i_ack) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ptr   <= '0;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            r_found <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan <= n_scan;
        r_cnt  <= n_cnt;
    end

    assign o_scan_idx   = r_scan;
    assign o_stat.idle  = (r_state == S_IDLE);
    assign o_stat.done  = (r_state == S_DONE);
    assign o_stat.found = r_found;

endmodule

>>> hw/rtl/tlb_victim_select_and_fill_top.sv
// TLB victim select and fill: round-robin victim pointer with per-entry locks.
// Tick and lock words take effect in the cycle they are accepted; ready stays high.
// Replace words scan one lock bit per cycle, starting at the victim pointer; ready stays low
// through the scan and returns once the result is registered, so a new replace word is taken only
// after the last one is through; a held result stalls the next replace after its scan.
// Synchronous active-low reset clears the pointer, all lock bits and the output valid flag.
// Depends on tvsf_pkg, tvsf_lock_file, tvsf_scan_ctrl.
module tlb_victim_select_and_fill_top #(
    parameter int ENTRIES = tvsf_pkg::ENTRIES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // lock_index[5:0], virt_addr[37:6], phys_addr[69:38], exec_bit[70], write_bit[71],
    // io_bit[72], zero pad
    input  logic [tvsf_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // req_type[1:0]
    input  logic [tvsf_pkg::REQ_W-1:0]      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // entry_index[5:0], virt_page_addr[37:6], phys_page_addr[69:38], writable[70],
    // executable[71], cachable[72], zero pad
    output logic [tvsf_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // status[1:0]
    output logic [tvsf_pkg::STATUS_W-1:0]   m_axis_tuser
);
    import tvsf_pkg::*;

    localparam int PW  = $clog2(ENTRIES);
    localparam int PAD = OUT_DATA_W - (ENTRY_IDX_W + 2 * ADDR_W + 3);

    logic                   w_in_acc;
    logic [LOCK_IDX_W-1:0]  w_lock_idx;
    logic [ADDR_W-1:0]      w_va, w_pa;
    logic                   w_fx, w_fw, w_fi;
    logic                   w_tick, w_lock, w_replace, w_ack;
    logic                   w_locked;
    logic [PW-1:0]          w_scan_idx;
    t_scan_stat             w_stat;

    logic [ADDR_W-1:0]      r_va, r_pa;
    logic                   r_fx, r_fw, r_fi;

    logic                   r_out_valid;
    logic [OUT_DATA_W-1:0]  r_out_data, n_out_data;
    logic [STATUS_W-1:0]    r_out_user, n_out_user;

    assign w_lock_idx = s_axis_tdata[5:0];
    assign w_va       = s_axis_tdata[37:6];
    assign w_pa       = s_axis_tdata[69:38];
    assign w_fx       = s_axis_tdata[70];
    assign w_fw       = s_axis_tdata[71];
    assign w_fi       = s_axis_tdata[72];

    assign s_axis_tready = w_stat.idle;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_tick        = w_in_acc && (s_axis_tuser == REQ_TICK);
    assign w_lock        = w_in_acc && (s_axis_tuser == REQ_LOCK);
    assign w_replace     = w_in_acc && (s_axis_tuser == REQ_REPLACE);
    assign w_ack         = w_stat.done && (!r_out_valid || m_axis_tready);

    tvsf_lock_file #(
        .ENTRIES (ENTRIES),
        .PW      (PW)
    ) u_lock_file (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_set     (w_lock),
        .i_set_idx (w_lock_idx),
        .i_rd_idx  (w_scan_idx),
        .o_locked  (w_locked)
    );

    tvsf_scan_ctrl #(
        .ENTRIES (ENTRIES),
        .PW      (PW)
    ) u_scan_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tick     (w_tick),
        .i_replace  (w_replace),
        .i_ack      (w_ack),
        .i_locked   (w_locked),
        .o_scan_idx (w_scan_idx),
        .o_stat     (w_stat)
    );

    // hold the miss word while the scan runs
    always_ff @(posedge i_clk) begin
        if (w_replace) begin
            r_va <= w_va;
            r_pa <= w_pa;
            r_fx <= w_fx;
            r_fw <= w_fw;
            r_fi <= w_fi;
        end
    end

    always_comb begin
        logic [ADDR_W-1:0] vpa;
        logic [ADDR_W-1:0] ppa;
        vpa = {r_va[ADDR_W-1:PAGE_OFS_W], {PAGE_OFS_W{1'b0}}};
        ppa = {r_pa[ADDR_W-1:PAGE_OFS_W], {PAGE_OFS_W{1'b0}}};
        n_out_data = '0;
        n_out_user = ST_OK;
        priority if (!w_stat.found) begin
            n_out_user = ST_ALL_LOCKED;
        end else if (r_fx) begin
            n_out_data = {{PAD{1'b0}}, 1'b1, 1'b1, 1'b1, ppa, vpa, ENTRY_IDX_W'(w_scan_idx)};
        end else if (r_fw) begin
            n_out_data = {{PAD{1'b0}}, 1'b1, 1'b0, 1'b1, ppa, vpa, ENTRY_IDX_W'(w_scan_idx)};
        end else if (r_fi) begin
            n_out_data = {{PAD{1'b0}}, 1'b0, 1'b0, 1'b0, ppa, vpa, ENTRY_IDX_W'(w_scan_idx)};
        end else begin
            n_out_user = ST_BAD_KIND;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ack) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ack) begin
            r_out_data <= n_out_data;
            r_out_user <= n_out_user;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule

>>> verif/tlb_victim_select_and_fill_checker.sv
// Checker for the TLB victim select and fill block: predicts each fill result.
// Watches both stream channels and compares results with a queue of expected fills.
// Depends on tvsf_pkg.
module tlb_victim_select_and_fill_checker #(
    parameter int ENTRIES = tvsf_pkg::ENTRIES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic [tvsf_pkg::IN_DATA_W-1:0]  i_in_data,
    input  logic [tvsf_pkg::REQ_W-1:0]      i_in_user,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic [tvsf_pkg::OUT_DATA_W-1:0] i_out_data,
    input  logic [tvsf_pkg::STATUS_W-1:0]   i_out_user,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_fill_count,
    output int                              o_all_locked_count,
    output int                              o_bad_kind_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import tvsf_pkg::*;

    typedef struct packed {
        logic [6:0]        pad;
        logic              io;
        logic              wr;
        logic              ex;
        logic [ADDR_W-1:0] pa;
        logic [ADDR_W-1:0] va;
        logic [5:0]        idx;
    } t_req_fields;

    typedef struct packed {
        logic [6:0]             pad;
        logic                   cachable;
        logic                   executable;
        logic                   writable;
        logic [ADDR_W-1:0]      phys_page;
        logic [ADDR_W-1:0]      virt_page;
        logic [ENTRY_IDX_W-1:0] entry;
    } t_fill_fields;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        t_fill_fields        f;
    } t_fill_result;

    localparam logic [ADDR_W-1:0] PG_ALIGN = {{(ADDR_W-PAGE_OFS_W){1'b1}}, {PAGE_OFS_W{1'b0}}};

    logic [ENTRY_IDX_W-1:0] victim_ptr;
    logic [ENTRIES-1:0]     lock_bits;
    t_fill_result           fill_q[$];
    int                     fails        = 0;
    int                     n_fill       = 0;
    int                     n_all_locked = 0;
    int                     n_bad_kind   = 0;

    task automatic report(input string name, input logic [31:0] want_v,
                          input logic [31:0] got_v);
        if (want_v !== got_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_req_fields            req;
        t_fill_result           want;
        t_fill_result           got;
        logic [ENTRY_IDX_W-1:0] slot;
        logic                   hit;
        if (!i_rst_n) begin
            victim_ptr = '0;
            lock_bits  = '0;
            fill_q.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                req = t_req_fields'(i_in_data);
                case (i_in_user)
                    REQ_TICK: begin
                        victim_ptr = (victim_ptr == ENTRIES - 1) ? '0 : victim_ptr + 1'b1;
                    end
                    REQ_LOCK: begin
                        if (req.idx < ENTRIES)
                            lock_bits[req.idx] = 1'b1;
                    end
                    REQ_REPLACE: begin
                        want = '0;
                        slot = victim_ptr;
                        hit  = 1'b0;
                        for (int n = 0; n < ENTRIES && !hit; n++) begin
                            if (!lock_bits[slot])
                                hit = 1'b1;
                            else
                                slot = (slot == ENTRIES - 1) ? '0 : slot + 1'b1;
                        end
                        if (!hit) begin
                            want.status = ST_ALL_LOCKED;
                        end else begin
                            victim_ptr = slot;
                            if (req.ex || req.wr || req.io) begin
                                want.f.writable   = req.ex | req.wr;
                                want.f.executable = req.ex;
                                want.f.cachable   = req.ex | req.wr;
                                want.f.entry      = slot;
                                want.f.virt_page  = req.va & PG_ALIGN;
                                want.f.phys_page  = req.pa & PG_ALIGN;
                                want.status       = ST_OK;
                            end else begin
                                want.status = ST_BAD_KIND;
                            end
                        end
                        fill_q.push_back(want);
                    end
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                got.status = i_out_user;
                got.f      = t_fill_fields'(i_out_data);
                if (got.status == ST_OK)
                    n_fill++;
                else if (got.status == ST_ALL_LOCKED)
                    n_all_locked++;
                else
                    n_bad_kind++;
                if (fill_q.size() == 0) begin
                    $error("result word with no request waiting: status 0x%0h data 0x%0h",
                           i_out_user, i_out_data);
                    fails++;
                end else begin
                    want = fill_q.pop_front();
                    report("status", 32'(want.status), 32'(got.status));
                    report("entry_index", 32'(want.f.entry), 32'(got.f.entry));
                    report("virt_page_addr", want.f.virt_page, got.f.virt_page);
                    report("phys_page_addr", want.f.phys_page, got.f.phys_page);
                    report("writable", 32'(want.f.writable), 32'(got.f.writable));
                    report("executable", 32'(want.f.executable), 32'(got.f.executable));
                    report("cachable", 32'(want.f.cachable), 32'(got.f.cachable));
                end
            end
        end
        o_fail_count       <= fails;
        o_pending          <= fill_q.size();
        o_fill_count       <= n_fill;
        o_all_locked_count <= n_all_locked;
        o_bad_kind_count   <= n_bad_kind;
    end

endmodule

>>> verif/tb_tlb_victim_select_and_fill_top.sv
// Testbench top for the TLB victim select and fill block: clock, reset and request stimulus.
// Result checking lives in tlb_victim_select_and_fill_checker; depends on tvsf_pkg.
module tb_tlb_victim_select_and_fill_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tvsf_pkg::*;

    localparam int              ENTRIES    = ENTRIES_DEF;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int              RAND_WORDS = 1300;
    localparam int              LONG_HOLD  = 400;
    localparam int              IDLE_LIMIT = 5000;
    localparam int              DIRECTED_N = 17;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [REQ_W-1:0]      s_axis_tuser  = REQ_TICK;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [STATUS_W-1:0]   m_axis_tuser;

    int fail_count;
    int pending;
    int fill_count;
    int all_locked_count;
    int bad_kind_count;
    int sent;
    int burst_left;
    int idle_cycles = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    tlb_victim_select_and_fill_top #(
        .ENTRIES(ENTRIES)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    tlb_victim_select_and_fill_checker #(
        .ENTRIES(ENTRIES)
    ) i_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (s_axis_tvalid),
        .i_in_ready         (s_axis_tready),
        .i_in_data          (s_axis_tdata),
        .i_in_user          (s_axis_tuser),
        .i_out_valid        (m_axis_tvalid),
        .i_out_ready        (m_axis_tready),
        .i_out_data         (m_axis_tdata),
        .i_out_user         (m_axis_tuser),
        .o_fail_count       (fail_count),
        .o_pending          (pending),
        .o_fill_count       (fill_count),
        .o_all_locked_count (all_locked_count),
        .o_bad_kind_count   (bad_kind_count)
    );

    // Receiver: one long hold-off after the directed words, then random stall modes.
    int       hold_left = 0;
    logic     long_hold_done = 1'b0;
    int       in_seen = 0;
    int       mode = 0;
    int       mode_left = 0;
    int       phase = 0;

    always @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready)
            in_seen <= in_seen + 1;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!long_hold_done && in_seen >= DIRECTED_N) begin
            long_hold_done <= 1'b1;
            hold_left      <= LONG_HOLD;
            m_axis_tready  <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                mode      <= $urandom_range(0, 3);
                mode_left <= $urandom_range(8, 80);
            end else begin
                mode_left <= mode_left - 1;
            end
            phase <= phase + 1;
            case (mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= 1'($urandom_range(0, 1));
                2: m_axis_tready <= ($urandom_range(0, 7) == 0);
                default: m_axis_tready <= (phase % 4 != 3);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
            $display("tlb_victim_select_and_fill_top test failed");
            $finish;
        end
    end

    function automatic logic [31:0] pick_addr();
        case ($urandom_range(0, 7))
            0: pick_addr = 32'h0000_0000;
            1: pick_addr = 32'hFFFF_FFFF;
            default: pick_addr = $urandom;
        endcase
    endfunction

    task automatic send_word(input logic [REQ_W-1:0] kind, input logic [5:0] idx,
                             input logic [31:0] va, input logic [31:0] pa,
                             input logic fx, input logic fw, input logic fi);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {7'd0, fi, fw, fx, pa, va, idx};
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        sent++;
        burst_left--;
        if (burst_left <= 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
            burst_left = $urandom_range(1, 40);
        end
    endtask

    task automatic send_random(input logic [REQ_W-1:0] kind);
        logic [2:0] flags;
        flags = 3'($urandom_range(0, 7));
        send_word(kind, 6'($urandom_range(0, 63)), pick_addr(), pick_addr(),
                  flags[0], flags[1], flags[2]);
    endtask

    initial begin : stimulus
        int r;
        int keep;
        sent       = 0;
        burst_left = $urandom_range(1, 40);
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_word(REQ_REPLACE, 6'd0,  32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 1'b0);
        send_word(REQ_REPLACE, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0);
        send_word(REQ_REPLACE, 6'd21, 32'h1234_5FFF, 32'h89AB_C001, 1'b0, 1'b0, 1'b1);
        send_word(REQ_REPLACE, 6'd42, 32'hDEAD_BEEF, 32'hCAFE_F00D, 1'b1, 1'b1, 1'b1);
        send_word(REQ_REPLACE, 6'd5,  32'h0000_1FFF, 32'hFFFF_E000, 1'b0, 1'b1, 1'b1);
        send_word(REQ_REPLACE, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);
        send_word(REQ_TICK,    6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
        send_word(REQ_LOCK,    6'd1,  32'h0,         32'h0,         1'b0, 1'b0, 1'b0);
        send_word(REQ_LOCK,    6'd2,  32'h0,         32'h0,         1'b0, 1'b0, 1'b0);
        send_word(REQ_REPLACE, 6'd0,  32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b1, 1'b0, 1'b0);
        send_word(REQ_LOCK,    6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
        send_word(REQ_LOCK,    6'd0,  32'h0,         32'h0,         1'b0, 1'b0, 1'b0);
        send_word(REQ_UNUSED,  6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
        send_word(REQ_TICK,    6'd0,  32'h0,         32'h0,         1'b0, 1'b0, 1'b0);
        send_word(REQ_LOCK,    6'd4,  32'h0,         32'h0,         1'b0, 1'b0, 1'b0);
        send_word(REQ_REPLACE, 6'd0,  32'h7777_7777, 32'h8888_8888, 1'b0, 1'b0, 1'b0);
        send_word(REQ_REPLACE, 6'd9,  32'h0123_4567, 32'h89AB_CDEF, 1'b0, 1'b0, 1'b1);

        for (int i = 0; i < RAND_WORDS; i++) begin
            r = $urandom_range(0, 99);
            if (r < 42)
                send_random(REQ_TICK);
            else if (r < 45)
                send_random(REQ_LOCK);
            else if (r < 48)
                send_random(REQ_UNUSED);
            else
                send_random(REQ_REPLACE);
        end

        // Lock all but one entry, fill into it, then lock it too.
        keep = $urandom_range(0, ENTRIES - 1);
        for (int i = 0; i < ENTRIES; i++) begin
            if (i != keep)
                send_word(REQ_LOCK, 6'(i), pick_addr(), pick_addr(), 1'b0, 1'b1, 1'b0);
            if ($urandom_range(0, 3) == 0)
                send_random(REQ_TICK);
        end
        repeat (4) send_random(REQ_REPLACE);
        send_random(REQ_TICK);
        send_random(REQ_REPLACE);
        send_word(REQ_LOCK, 6'(keep), pick_addr(), pick_addr(), 1'b1, 1'b0, 1'b1);
        send_word(REQ_REPLACE, 6'd0, 32'hFFFF_FFFF, 32'h1234_5678, 1'b1, 1'b0, 1'b0);
        send_word(REQ_REPLACE, 6'd63, 32'h0, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);
        send_word(REQ_REPLACE, 6'd7, 32'h0BAD_F00D, 32'h0, 1'b0, 1'b0, 1'b1);
        send_random(REQ_TICK);
        send_random(REQ_UNUSED);
        repeat (3) send_random(REQ_REPLACE);
        s_axis_tvalid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (ENTRIES + 8) @(posedge i_clk);

        $display("Summary: %0d request words sent, with one long output stall and all-locked runs",
                 sent);
        $display("Results checked: %0d fills, %0d all-locked, %0d unknown kind",
                 fill_count, all_locked_count, bad_kind_count);
        if (fail_count == 0)
            $display("tlb_victim_select_and_fill_top test passed");
        else
            $display("tlb_victim_select_and_fill_top test failed");
        $finish;
    end

endmodule
